[hw/rtl/barometric_pressure_compensation_unit_defines.svh]
// ---------------------------------------------------------------------------
// Barometric pressure compensation unit: assertion macros
// Clocked assertion wrappers used by the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH

// checked only while out of reset
`define BPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/bpc_pkg.sv]
// ---------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric pressure compensation unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpc_pkg;

  // field widths
  localparam int RAW_T_W = 16;
  localparam int RAW_P_W = 24;
  localparam int TEMP_W  = 16;
  localparam int PRESS_W = 20;

  // divider sizes: temperature quotient and pressure quotient
  localparam int TDIV_NW = 27;
  localparam int TDIV_DW = 19;
  localparam int PDIV_NW = 33;
  localparam int PDIV_DW = 17;

  // compensation constants
  localparam int                 B6_OFFSET = 4000;
  localparam int                 T_ROUND   = 8;
  localparam int                 B3_ROUND  = 2;
  localparam logic [31:0]        B4_BIAS   = 32'd32768;
  localparam logic [15:0]        P_SCALE   = 16'd50000;
  localparam logic [11:0]        C_SQ      = 12'd3038;
  localparam logic signed [14:0] C_LIN     = -15'sd7357;
  localparam int                 C_OFS     = 3791;
  localparam logic [19:0]        PRESS_MAX = 20'hFFFFF;
  localparam int                 TEMP_MAX  = 32767;
  localparam int                 TEMP_MIN  = -32768;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CAL_FIRST  = 2'd0,
    CFG_CAL_SECOND = 2'd1,
    CFG_CAL_THIRD  = 2'd2,
    CFG_OSS        = 2'd3
  } cfg_idx_t;

  // decoded calibration set, raw bit patterns
  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  // sideband through the temperature divider
  typedef struct packed {
    logic [18:0] x1;
    logic        neg;
    logic        den_zero;
    logic [23:0] up;
  } tside_t;

  // sideband through the pressure divider
  typedef struct packed {
    logic [15:0] temp;
    logic        t_fault;
    logic        p_fault;
    logic        dbl;
  } pside_t;

  // one result beat
  typedef struct packed {
    logic        math_fault;
    logic [19:0] pressure_pa;
    logic [15:0] temperature_tenths;
  } res_t;

endpackage

[hw/rtl/bpc_div.sv]
// ---------------------------------------------------------------------------
// bpc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_div
  import bpc_pkg::*;
#(
  parameter int NW = TDIV_NW,
  parameter int DW = TDIV_DW,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] quotient,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [DW-1:0] dvs_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] dvs_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic [DW-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign quo_in  = dividend;
      assign dvs_in  = divisor;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign dvs_in  = dvs_r[i-1];
      assign side_in = side_r[i-1];
    end

    // shift in next dividend bit, trial subtract
    assign trial   = {rem_in, quo_in[NW-1]};
    assign diff    = trial - {1'b0, dvs_in};
    assign take    = (trial >= {1'b0, dvs_in});
    assign rem_nxt = take ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        quo_r[i]  <= {quo_in[NW-2:0], take};
        dvs_r[i]  <= dvs_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign quotient  = quo_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

[hw/rtl/bpc_temp.sv]
// ---------------------------------------------------------------------------
// bpc_temp
// Front end: raw temperature term and operands of the temperature division.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_temp
  import bpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [RAW_T_W-1:0]   raw_temp,
  input  logic [RAW_P_W-1:0]   raw_press,
  input  cal_t                 cal,
  output logic                 div_valid,
  output logic [TDIV_NW-1:0]   div_num,
  output logic [TDIV_DW-1:0]   div_den,
  output tside_t               div_side
);

  logic               v1_r;
  logic signed [33:0] prod_r;
  logic [23:0]        up_r;

  logic signed [16:0] dt;
  logic signed [33:0] prod_nxt;
  logic [23:0]        up_nxt;

  // (ut - ac6) * ac5, pressure alignment
  always_comb begin
    dt       = $signed({1'b0, raw_temp}) - $signed({1'b0, cal.ac6});
    prod_nxt = dt * $signed({1'b0, cal.ac5});
    up_nxt   = raw_press >> (4'd8 - {2'b00, cal.oss});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      up_r   <= up_nxt;
    end
  end

  logic               v2_r;
  logic [26:0]        num_r;
  logic [18:0]        den_r;
  tside_t             side_r;

  logic signed [18:0] x1;
  logic signed [19:0] den;
  logic signed [26:0] num;
  logic [26:0]        num_mag;
  logic [19:0]        den_mag;
  tside_t             side_nxt;

  // divisor x1 + md, dividend mc * 2048, as magnitudes plus sign
  always_comb begin
    x1                = prod_r[33:15];
    den               = 20'(x1) + 20'($signed(cal.md));
    num               = $signed({cal.mc, 11'b0});
    num_mag           = num[26] ? 27'(-num) : 27'(num);
    den_mag           = den[19] ? 20'(-den) : 20'(den);
    side_nxt.x1       = x1;
    side_nxt.neg      = num[26] ^ den[19];
    side_nxt.den_zero = (den == '0);
    side_nxt.up       = up_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_mag;
      den_r  <= den_mag[18:0];
      side_r <= side_nxt;
    end
  end

  assign div_valid = v2_r;
  assign div_num   = num_r;
  assign div_den   = den_r;
  assign div_side  = side_r;

endmodule

[hw/rtl/bpc_coef.sv]
// ---------------------------------------------------------------------------
// bpc_coef
// Temperature result, then b3, b4 and b7 for the pressure division.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_coef
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [TDIV_NW-1:0] quo,
  input  tside_t             side,
  input  cal_t               cal,
  output logic               div_valid,
  output logic [PDIV_NW-1:0] div_num,
  output logic [PDIV_DW-1:0] div_den,
  output pside_t             div_side
);

  // stage 1: b5, temperature, b6
  logic signed [27:0] x2s, b5, tq, b6;
  logic [15:0]        temp_nxt;

  always_comb begin
    x2s = side.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    b5  = 28'($signed(side.x1)) + x2s;
    tq  = (b5 + 28'(T_ROUND)) >>> 4;
    b6  = b5 - 28'(B6_OFFSET);
    if (tq > 28'(TEMP_MAX)) begin
      temp_nxt = 16'h7FFF;
    end else if (tq < 28'(TEMP_MIN)) begin
      temp_nxt = 16'h8000;
    end else begin
      temp_nxt = tq[15:0];
    end
  end

  logic               v1_r;
  logic signed [27:0] b6_r;
  logic [15:0]        temp1_r;
  logic               tf1_r;
  logic [23:0]        up1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b6_r    <= b6;
      temp1_r <= side.den_zero ? '0 : temp_nxt;
      tf1_r   <= side.den_zero;
      up1_r   <= side.up;
    end
  end

  // stage 2: products of b6
  logic signed [55:0] b6sq;
  logic signed [43:0] ac2b6, ac3b6;

  always_comb begin
    b6sq  = b6_r * b6_r;
    ac2b6 = $signed(cal.ac2) * b6_r;
    ac3b6 = $signed(cal.ac3) * b6_r;
  end

  logic               v2_r;
  logic signed [55:0] b6sq_r;
  logic signed [43:0] ac2b6_r, ac3b6_r;
  logic [15:0]        temp2_r;
  logic               tf2_r;
  logic [23:0]        up2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b6sq_r  <= b6sq;
      ac2b6_r <= ac2b6;
      ac3b6_r <= ac3b6;
      temp2_r <= temp1_r;
      tf2_r   <= tf1_r;
      up2_r   <= up1_r;
    end
  end

  // stage 3: b2 and b1 terms
  logic signed [43:0] s;
  logic signed [59:0] pb1, pb2;

  always_comb begin
    s   = b6sq_r[55:12];
    pb2 = $signed(cal.b2) * s;
    pb1 = $signed(cal.b1) * s;
  end

  logic               v3_r;
  logic signed [59:0] pb1_r, pb2_r;
  logic signed [43:0] ac2b6_3_r, ac3b6_3_r;
  logic [15:0]        temp3_r;
  logic               tf3_r;
  logic [23:0]        up3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pb1_r     <= pb1;
      pb2_r     <= pb2;
      ac2b6_3_r <= ac2b6_r;
      ac3b6_3_r <= ac3b6_r;
      temp3_r   <= temp2_r;
      tf3_r     <= tf2_r;
      up3_r     <= up2_r;
    end
  end

  // stage 4: b3 (low 32 bits only) and the b4 multiplicand
  logic signed [48:0] bx1;
  logic signed [32:0] bx2;
  logic signed [49:0] bx3;
  logic [33:0]        a34, y34;
  logic signed [30:0] px1;
  logic signed [43:0] px2;
  logic signed [44:0] psum;
  logic [31:0]        b3lo, xb;

  always_comb begin
    bx1  = pb2_r[59:11];
    bx2  = ac2b6_3_r[43:11];
    bx3  = 50'(bx1) + 50'(bx2);
    a34  = bx3[33:0] + (34'($signed(cal.ac1)) << 2);
    y34  = (a34 << cal.oss) + 34'(B3_ROUND);
    b3lo = y34[33:2];
    px1  = ac3b6_3_r[43:13];
    px2  = pb1_r[59:16];
    psum = 45'(px1) + 45'(px2) + 45'sd2;
    xb   = psum[33:2] + B4_BIAS;
  end

  logic               v4_r;
  logic [31:0]        b3lo_r, xb_r;
  logic [15:0]        temp4_r;
  logic               tf4_r;
  logic [23:0]        up4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b3lo_r  <= b3lo;
      xb_r    <= xb;
      temp4_r <= temp3_r;
      tf4_r   <= tf3_r;
      up4_r   <= up3_r;
    end
  end

  // stage 5: b4 and b7, both wrapping at 32 bits
  logic [47:0] b4p, b7p;
  logic [31:0] diff;
  logic [15:0] k;

  always_comb begin
    b4p  = cal.ac4 * xb_r;
    diff = {8'b0, up4_r} - b3lo_r;
    k    = P_SCALE >> cal.oss;
    b7p  = diff * k;
  end

  logic               v5_r;
  logic [16:0]        b4_r;
  logic [31:0]        b7_r;
  logic [15:0]        temp5_r;
  logic               tf5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b4_r    <= b4p[31:15];
      b7_r    <= b7p[31:0];
      temp5_r <= temp4_r;
      tf5_r   <= tf4_r;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // b7 * 2 / b4 below 2^31, (b7 / b4) * 2 above
  assign div_valid        = v5_r;
  assign div_num          = b7_r[31] ? {1'b0, b7_r} : {b7_r, 1'b0};
  assign div_den          = b4_r;
  assign div_side.temp    = temp5_r;
  assign div_side.t_fault = tf5_r;
  assign div_side.p_fault = (b4_r == '0);
  assign div_side.dbl     = b7_r[31];

endmodule

[hw/rtl/bpc_final.sv]
// ---------------------------------------------------------------------------
// bpc_final
// Pressure correction polynomial, saturation and fault masking.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_final
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [PDIV_NW-1:0] quo,
  input  pside_t             side,
  output logic               res_valid,
  output res_t               res
);

  // stage 1: p, (p >> 8) squared, linear term
  logic [33:0]        q;
  logic [25:0]        ph;
  logic [51:0]        sq;
  logic signed [49:0] m;

  always_comb begin
    q  = side.dbl ? {quo, 1'b0} : {1'b0, quo};
    ph = q[33:8];
    sq = ph * ph;
    m  = $signed({1'b0, q}) * C_LIN;
  end

  logic               v1_r;
  logic [33:0]        q1_r;
  logic [51:0]        sq_r;
  logic signed [49:0] m_r;
  pside_t             side1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r    <= q;
      sq_r    <= sq;
      m_r     <= m;
      side1_r <= side;
    end
  end

  // stage 2: scale the square term
  logic [63:0] sqk;

  assign sqk = sq_r * C_SQ;

  logic               v2_r;
  logic [33:0]        q2_r;
  logic [47:0]        x1_r;
  logic signed [33:0] x2_r;
  pside_t             side2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q2_r    <= q1_r;
      x1_r    <= sqk[63:16];
      x2_r    <= m_r[49:16];
      side2_r <= side1_r;
    end
  end

  // stage 3: add the correction, clamp, apply faults
  logic signed [49:0] corr, p;
  res_t               res_nxt;

  always_comb begin
    corr = $signed({2'b00, x1_r}) + 50'(x2_r) + 50'(C_OFS);
    p    = $signed({16'b0, q2_r}) + (corr >>> 4);
    res_nxt.math_fault         = side2_r.t_fault | side2_r.p_fault;
    res_nxt.temperature_tenths = side2_r.temp;
    if (side2_r.t_fault || side2_r.p_fault || p < 0) begin
      res_nxt.pressure_pa = '0;
    end else if (p > $signed({30'b0, PRESS_MAX})) begin
      res_nxt.pressure_pa = PRESS_MAX;
    end else begin
      res_nxt.pressure_pa = p[19:0];
    end
  end

  logic v3_r;
  res_t res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res_valid = v3_r;
  assign res       = res_r;

endmodule

[hw/rtl/barometric_pressure_compensation_unit.sv]
// Barometric pressure compensation unit. Takes one raw temperature and raw
// pressure beat per clock while in_tready is high and returns the compensated
// temperature in tenths of a degree, the pressure in pascals and a fault flag,
// one result beat per input beat, in order. The datapath is a fixed pipeline:
// 2 front-end stages, a 27-stage temperature divider, 5 coefficient stages, a
// 33-stage pressure divider and 3 correction stages, then the output register.
// Throughput is one beat per cycle while the pipeline is not frozen; the whole
// pipeline freezes only while both the output register and its skid entry
// hold results that the sink has not taken, so in_tready is a register. The
// fault flag marks a zero divisor; when the temperature divisor is zero both
// values read 0, when the pressure divisor is zero the temperature is still
// valid and the pressure reads 0. Calibration writes are taken at any time
// (cfg_ready is always high) but belong between runs.
`timescale 1ns / 1ps

module barometric_pressure_compensation_unit
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_temp [15:0], raw_press [39:16]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // temperature_tenths [15:0], pressure_pa [35:16], zero
  output logic [0:0]  out_tuser,  // math_fault [0]
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration registers
  logic [63:0] cal_first_r;
  logic [63:0] cal_second_r;
  logic [31:0] cal_third_r;   // mc and md; mb is not used
  logic [1:0]  oss_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_first_r  <= '0;
      cal_second_r <= '0;
      cal_third_r  <= '0;
      oss_r        <= 2'd3;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAL_FIRST:  cal_first_r  <= cfg_data;
        CFG_CAL_SECOND: cal_second_r <= cfg_data;
        CFG_CAL_THIRD:  cal_third_r  <= cfg_data[47:16];
        CFG_OSS:        oss_r        <= cfg_data[1:0];
        default:        ;
      endcase
    end
  end

  // calibration field decode
  cal_t cal;

  always_comb begin
    cal.ac1 = cal_first_r[15:0];
    cal.ac2 = cal_first_r[31:16];
    cal.ac3 = cal_first_r[47:32];
    cal.ac4 = cal_first_r[63:48];
    cal.ac5 = cal_second_r[15:0];
    cal.ac6 = cal_second_r[31:16];
    cal.b1  = cal_second_r[47:32];
    cal.b2  = cal_second_r[63:48];
    cal.mc  = cal_third_r[15:0];
    cal.md  = cal_third_r[31:16];
    cal.oss = oss_r;
  end

  // pipeline advance: frozen only while the skid entry is occupied
  logic skid_valid_r;
  logic en;

  assign en        = ~skid_valid_r;
  assign in_tready = en;

  // front end
  logic               t_valid;
  logic [TDIV_NW-1:0] t_num;
  logic [TDIV_DW-1:0] t_den;
  tside_t             t_side;

  bpc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .raw_temp  (in_tdata[15:0]),
    .raw_press (in_tdata[39:16]),
    .cal       (cal),
    .div_valid (t_valid),
    .div_num   (t_num),
    .div_den   (t_den),
    .div_side  (t_side)
  );

  // temperature divider
  logic               tq_valid;
  logic [TDIV_NW-1:0] tq;
  logic [$bits(tside_t)-1:0] tq_side;

  bpc_div #(
    .NW (TDIV_NW),
    .DW (TDIV_DW),
    .SW ($bits(tside_t))
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t_valid),
    .dividend  (t_num),
    .divisor   (t_den),
    .in_side   (t_side),
    .out_valid (tq_valid),
    .quotient  (tq),
    .out_side  (tq_side)
  );

  // coefficients
  logic               c_valid;
  logic [PDIV_NW-1:0] c_num;
  logic [PDIV_DW-1:0] c_den;
  pside_t             c_side;

  bpc_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (tq_valid),
    .quo       (tq),
    .side      (tside_t'(tq_side)),
    .cal       (cal),
    .div_valid (c_valid),
    .div_num   (c_num),
    .div_den   (c_den),
    .div_side  (c_side)
  );

  // pressure divider
  logic               pq_valid;
  logic [PDIV_NW-1:0] pq;
  logic [$bits(pside_t)-1:0] pq_side;

  bpc_div #(
    .NW (PDIV_NW),
    .DW (PDIV_DW),
    .SW ($bits(pside_t))
  ) u_pdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid),
    .dividend  (c_num),
    .divisor   (c_den),
    .in_side   (c_side),
    .out_valid (pq_valid),
    .quotient  (pq),
    .out_side  (pq_side)
  );

  // correction and clamp
  logic fin_valid;
  res_t fin_res;

  bpc_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pq_valid),
    .quo       (pq),
    .side      (pside_t'(pq_side)),
    .res_valid (fin_valid),
    .res       (fin_res)
  );

  // output register with one skid entry
  logic out_valid_r;
  res_t out_res_r;
  res_t skid_res_r;
  logic pop;
  logic push;

  assign pop  = out_valid_r & out_tready;
  assign push = en & fin_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_res_r <= skid_res_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_res_r <= fin_res;
      end else begin
        skid_res_r <= fin_res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_res_r.pressure_pa, out_res_r.temperature_tenths};
  assign out_tuser  = out_res_r.math_fault;

endmodule

[hw/rtl/bpc_checker.sv]
// ---------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the barometric pressure compensation unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "barometric_pressure_compensation_unit_defines.svh"

module bpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // no result beat right after reset
  `BPC_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid, "result valid after reset")

  // a faulted beat never carries a pressure
  `BPC_ASSERT(a_fault_press, (out_tvalid && out_tuser[0]) |-> (out_tdata[35:16] == 20'd0), "pressure set on fault")

  // input held off only behind a stalled result
  `BPC_ASSERT(a_hold_cause, !in_tready |-> (out_tvalid && $past(out_tvalid && !out_tready)), "input stalled without output stall")

  // stalled result beat holds
  `BPC_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result changed")

endmodule

bind barometric_pressure_compensation_unit bpc_checker u_bpc_checker (.*);

[tb/tb.sv]
// ---------------------------------------------------------------------------
// Barometric pressure compensation unit testbench
// Drives raw temperature and pressure beats through the unit under several
// calibration sets and oversampling settings, predicts each result with an
// independent integer model or a typed-in answer and compares every output beat in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bpc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // raw_temp [15:0], raw_press [39:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // temperature_tenths [15:0], pressure_pa [35:16], zero
  logic [0:0]  out_tuser;   // math_fault [0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  barometric_pressure_compensation_unit dut (.*);

  // expected result beat
  typedef struct {
    logic [15:0] temp;
    logic [19:0] press;
    logic        fault;
  } comp_res_t;

  // stimulus row with optional typed-in answer
  typedef struct {
    logic [15:0] ut;
    logic [23:0] up;
    bit          fixed;
    comp_res_t   ans;
  } row_t;

  comp_res_t   pending_q[$];
  logic [63:0] cal0, cal1, cal2;
  logic [1:0]  oss_set;
  int          send_idle_pct, recv_stall_pct;
  bit          hold_off;
  int          mismatches, results_seen, items_sent, idle_cycles;
  bit          stim_done;

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint asr_s(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint field_s(logic [63:0] w, int lo);
    return longint'($signed(w[lo +: 16]));
  endfunction

  function automatic longint field_u(logic [63:0] w, int lo);
    return longint'({48'd0, w[lo +: 16]});
  endfunction

  // integer compensation of one reading pair
  function automatic comp_res_t compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
    comp_res_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, x1, x2, x3, b3, b5, b6, den, t, p;
    logic [31:0] up32, b4, b7;
    logic [63:0] q, prod;
    ac1 = field_s(cal0, 0);  ac2 = field_s(cal0, 16);
    ac3 = field_s(cal0, 32); ac4 = field_u(cal0, 48);
    ac5 = field_u(cal1, 0);  ac6 = field_u(cal1, 16);
    b1 = field_s(cal1, 32);  b2 = field_s(cal1, 48);
    mc = field_s(cal2, 16);  md = field_s(cal2, 32);
    ut = longint'({48'd0, ut_raw});
    up32 = {8'd0, up_raw} >> (8 - oss_set);
    r.temp = '0; r.press = '0; r.fault = 1'b0;
    x1 = asr_s((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.fault = 1'b1;
      return r;
    end
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t = asr_s(b5 + 8, 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    r.temp = t[15:0];
    b6 = b5 - 4000;
    x1 = asr_s(b2 * asr_s(b6 * b6, 12), 11);
    x2 = asr_s(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = asr_s((ac1 * 4 + x3) * (longint'(1) << oss_set) + 2, 2);
    x1 = asr_s(ac3 * b6, 13);
    x2 = asr_s(b1 * asr_s(b6 * b6, 12), 16);
    x3 = asr_s(x1 + x2 + 2, 2);
    prod = 64'(ac4) * {32'd0, 32'(x3 + 32768)};
    b4 = prod[31:0] >> 15;
    prod = {32'd0, 32'(up32 - 32'(b3))} * {32'd0, 32'd50000 >> oss_set};
    b7 = prod[31:0];
    if (b4 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    if (b7 < 32'h8000_0000) q = ({32'd0, b7} * 2) / {32'd0, b4};
    else q = ({32'd0, b7} / {32'd0, b4}) * 2;
    p = longint'(q);
    x1 = (p >>> 8) * (p >>> 8);
    x1 = asr_s(x1 * 3038, 16);
    x2 = asr_s(-7357 * p, 16);
    p = p + asr_s(x1 + x2 + 3791, 4);
    if (p < 0) p = 0;
    if (p > 1048575) p = 1048575;
    r.press = p[19:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    comp_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (pending_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        e = pending_q.pop_front();
        if (out_tdata[15:0] !== e.temp || out_tdata[35:16] !== e.press ||
            out_tdata[39:36] !== 4'd0 || out_tuser[0] !== e.fault) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: exp t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
                     $signed(e.temp), e.press, e.fault, $signed(out_tdata[15:0]),
                     out_tdata[35:16], out_tuser[0]);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // long hold-off of the receiver so the pipeline fills and backs up
  task automatic hold_receiver(int cycles);
    hold_off = 1;
    repeat (cycles) @(posedge clk);
    hold_off = 0;
  endtask

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one input beat, prediction made at acceptance
  task automatic send_reading(logic [15:0] ut, logic [23:0] up, bit fixed, comp_res_t ans);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {up, ut};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(fixed ? ans : compensate(ut, up));
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CAL_FIRST:  cal0 = val;
      CFG_CAL_SECOND: cal1 = val;
      CFG_CAL_THIRD:  cal2 = {16'd0, val[47:0]};
      default:        oss_set = val[1:0];
    endcase
    @(posedge clk);
  endtask

  // typical factory calibration with random spread, or fully random words
  task automatic load_calibration(bit typical, logic [1:0] oss);
    logic [63:0] w0, w1, w2;
    if (typical) begin
      w0 = {16'(32741 + $urandom_range(2000) - 1000), 16'(-14383 + $urandom_range(400)),
            16'(-72 + $urandom_range(200)), 16'(408 + $urandom_range(8000))};
      w1 = {16'(4 + $urandom_range(200)), 16'(6190 + $urandom_range(200)),
            16'(23153 + $urandom_range(2000) - 1000) , 16'(32757 - $urandom_range(500))};
      w2 = {16'd0, 16'(2868 + $urandom_range(100)), 16'(-8711 + $urandom_range(400)),
            16'(-32768)};
    end else begin
      w0 = {$urandom, $urandom};
      w1 = {$urandom, $urandom};
      w2 = {$urandom, $urandom};
    end
    write_reg(CFG_CAL_FIRST, w0);
    write_reg(CFG_CAL_SECOND, w1);
    write_reg(CFG_CAL_THIRD, w2);
    write_reg(CFG_OSS, {62'($urandom), oss});
  endtask

  task automatic random_phase(int n, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (n) begin
      case ($urandom_range(3))
        0: send_reading(16'($urandom), 24'($urandom), 0, '{default: '0});
        default: send_reading(16'(20000 + $urandom_range(20000)),
                              24'($urandom_range(24'hFFFFFF)), 0, '{default: '0});
      endcase
    end
    drain();
  endtask

  row_t rows[$];

  initial begin
    comp_res_t zero_fault, dummy;
    row_t rw;
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0;
    cfg_valid = 0; cfg_index = CFG_CAL_FIRST; cfg_data = '0;
    hold_off = 0; send_idle_pct = 0; recv_stall_pct = 0;
    mismatches = 0; results_seen = 0; items_sent = 0; idle_cycles = 0;
    cal0 = '0; cal1 = '0; cal2 = '0; oss_set = 2'd3;
    zero_fault = '{temp: '0, press: '0, fault: 1'b1};
    dummy = '{default: '0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset every calibration word is zero: temperature divisor zero on every beat
    rows.push_back('{16'h0000, 24'h000000, 1, zero_fault});
    rows.push_back('{16'hFFFF, 24'hFFFFFF, 1, zero_fault});
    rows.push_back('{16'h8000, 24'h800000, 1, zero_fault});
    foreach (rows[i]) send_reading(rows[i].ut, rows[i].up, rows[i].fixed, rows[i].ans);
    drain();

    // extreme calibration words, field extremes, pressure divisor cases
    rows.delete();
    write_reg(CFG_CAL_FIRST, 64'h0000_8000_7FFF_8000);   // ac4 zero: pressure divisor zero
    write_reg(CFG_CAL_SECOND, 64'h7FFF_8000_FFFF_FFFF);
    write_reg(CFG_CAL_THIRD, 64'hFFFF_0001_7FFF_1234);
    write_reg(CFG_OSS, 64'd0);
    rw = '{16'h0000, 24'h000000, 0, dummy}; rows.push_back(rw);
    rw = '{16'hFFFF, 24'hFFFFFF, 0, dummy}; rows.push_back(rw);
    rw = '{16'hFFFE, 24'h000001, 0, dummy}; rows.push_back(rw);
    rw = '{16'h0001, 24'hFFFF00, 0, dummy}; rows.push_back(rw);
    foreach (rows[i]) send_reading(rows[i].ut, rows[i].up, rows[i].fixed, rows[i].ans);
    drain();
    rows.delete();
    load_calibration(1, 2'd3);
    rows.push_back('{16'h0000, 24'h000000, 0, dummy});
    rows.push_back('{16'hFFFF, 24'hFFFFFF, 0, dummy});
    rows.push_back('{16'd27898, 24'h5D2300, 0, dummy});
    rows.push_back('{16'd27000, 24'hA00000, 0, dummy});
    rows.push_back('{16'hAAAA, 24'h555555, 0, dummy});
    rows.push_back('{16'h5555, 24'hAAAAAA, 0, dummy});
    foreach (rows[i]) send_reading(rows[i].ut, rows[i].up, rows[i].fixed, rows[i].ans);
    drain();

    // random phases across oversampling settings and idling patterns
    load_calibration(1, 2'd0); random_phase(200, 0, 0);
    load_calibration(1, 2'd1); random_phase(200, 79, 0);
    load_calibration(0, 2'd2); random_phase(150, 0, 79);
    load_calibration(1, 2'd3); random_phase(200, 30, 30);
    load_calibration(0, 2'd3); random_phase(150, 0, 0);

    // receiver held off while the sender keeps offering
    load_calibration(1, 2'($urandom_range(3)));
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      hold_receiver(300);
      repeat (200) send_reading(16'($urandom), 24'($urandom), 0, dummy);
    join
    drain();
    load_calibration(1, 2'($urandom_range(3))); random_phase(200, 30, 30);

    $display("covered %0d readings, %0d results, 4 oversampling settings, fault cases",
             items_sent, results_seen);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_div.sv
hw/rtl/bpc_temp.sv
hw/rtl/bpc_coef.sv
hw/rtl/bpc_final.sv
hw/rtl/barometric_pressure_compensation_unit.sv
hw/rtl/bpc_checker.sv
tb/tb.sv
